/* sv/ras_pkg.sv */
package ras_pkg;

    localparam int POS_BITS  = 10;
    localparam int STEP_BITS = 3;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STEP_BITS-1:0] STEP_FETCH  = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_MID    = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_LO     = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_HI     = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_LAST   = 3'd4;
    localparam logic [STEP_BITS-1:0] STEP_DECIDE = 3'd5;

    typedef enum logic [1:0] {
        ADDR_MID,
        ADDR_LO,
        ADDR_HI
    } t_addr_sel;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_MID,
        CAP_LO,
        CAP_HI
    } t_cap_sel;

    typedef enum logic [1:0] {
        SEQ_FETCH,
        SEQ_RANGE,
        SEQ_NEXT,
        SEQ_DECIDE
    } t_seq_mode;

    typedef struct packed {
        t_addr_sel             addr_sel;
        t_cap_sel              cap_sel;
        t_seq_mode             seq_mode;
        logic [STEP_BITS-1:0]  next_step;
    } t_uop;

    typedef struct packed {
        logic      accept;
        logic      decide;
        t_addr_sel addr_sel;
        t_cap_sel  cap_sel;
    } t_ctrl;

    typedef struct packed {
        logic empty;
        logic done;
        logic out_block;
    } t_stat;

    function automatic t_uop ucode(input logic [STEP_BITS-1:0] step);
        t_uop u;
        case (step)
            STEP_FETCH:  u = '{ADDR_MID, CAP_NONE, SEQ_FETCH,  STEP_MID};
            STEP_MID:    u = '{ADDR_MID, CAP_NONE, SEQ_RANGE,  STEP_LO};
            STEP_LO:     u = '{ADDR_LO,  CAP_MID,  SEQ_NEXT,   STEP_HI};
            STEP_HI:     u = '{ADDR_HI,  CAP_LO,   SEQ_NEXT,   STEP_LAST};
            STEP_LAST:   u = '{ADDR_MID, CAP_HI,   SEQ_NEXT,   STEP_DECIDE};
            STEP_DECIDE: u = '{ADDR_MID, CAP_NONE, SEQ_DECIDE, STEP_MID};
            default:     u = '{ADDR_MID, CAP_NONE, SEQ_NEXT,   STEP_FETCH};
        endcase
        return u;
    endfunction

endpackage

/* sv/ras_ram.sv */
module ras_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ras_seq.sv */
module ras_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_op,
    input  ras_pkg::t_stat i_stat,
    output ras_pkg::t_ctrl o_ctrl,
    output logic           o_stall
);

    logic [ras_pkg::STEP_BITS-1:0] r_pc;
    logic [ras_pkg::STEP_BITS-1:0] n_pc;
    ras_pkg::t_uop                 uop;

    assign uop = ras_pkg::ucode(r_pc);

    always_comb begin
        case (uop.seq_mode)
            ras_pkg::SEQ_FETCH: begin
                n_pc = (i_valid && i_op == ras_pkg::OP_SEARCH) ? uop.next_step : r_pc;
            end
            ras_pkg::SEQ_RANGE: begin
                n_pc = i_stat.empty ? ras_pkg::STEP_DECIDE : uop.next_step;
            end
            ras_pkg::SEQ_DECIDE: begin
                if (i_stat.done) begin
                    n_pc = i_stat.out_block ? r_pc : ras_pkg::STEP_FETCH;
                end else begin
                    n_pc = uop.next_step;
                end
            end
            default: begin
                n_pc = uop.next_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ras_pkg::STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.accept   = i_valid && (uop.seq_mode == ras_pkg::SEQ_FETCH);
    assign o_ctrl.decide   = (uop.seq_mode == ras_pkg::SEQ_DECIDE);
    assign o_ctrl.addr_sel = uop.addr_sel;
    assign o_ctrl.cap_sel  = uop.cap_sel;
    assign o_stall         = (uop.seq_mode != ras_pkg::SEQ_FETCH);

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= ras_pkg::STEP_DECIDE)
        else $error("step counter left the program");

endmodule

/* sv/ras_dp.sv */
module ras_dp #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ras_pkg::t_ctrl                i_ctrl,
    input  logic                          i_op,
    input  logic                          i_first,
    input  logic signed [31:0]            i_element,
    input  logic signed [31:0]            i_target,
    input  logic                          i_stall,
    output ras_pkg::t_stat                o_stat,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [ras_pkg::POS_BITS-1:0]  o_position
);

    localparam int PW = (AW > ras_pkg::POS_BITS) ? AW : ras_pkg::POS_BITS;

    logic [CW-1:0]                 r_cnt;
    logic [AW-1:0]                 r_lo;
    logic [CW-1:0]                 r_hi;
    logic signed [VALUE_BITS-1:0]  r_tgt;
    logic signed [VALUE_BITS-1:0]  r_mv;
    logic signed [VALUE_BITS-1:0]  r_lv;
    logic signed [VALUE_BITS-1:0]  r_rv;
    logic                          r_out_valid;
    logic                          r_found;
    logic [ras_pkg::POS_BITS-1:0]  r_pos;

    logic signed [VALUE_BITS-1:0]  rdata;
    logic [VALUE_BITS-1:0]         ram_rdata;
    logic [AW-1:0]                 raddr;
    logic [AW-1:0]                 waddr;
    logic                          we;
    logic                          load_acc;
    logic                          search_acc;
    logic [CW:0]                   mid_sum;
    logic [AW-1:0]                 mid;
    logic [AW-1:0]                 hi_m1;
    logic [CW-1:0]                 lo_ext;
    logic [CW-1:0]                 len;
    logic                          nonempty;
    logic                          eq_m;
    logic                          eq_l;
    logic                          eq_r;
    logic                          hit;
    logic                          done;
    logic                          out_block;
    logic                          out_write;
    logic [AW-1:0]                 hit_pos;
    logic [PW-1:0]                 hit_pos_w;
    logic                          go_hi_mid;
    logic                          go_lo_mid;

    assign load_acc   = i_ctrl.accept && (i_op == ras_pkg::OP_LOAD);
    assign search_acc = i_ctrl.accept && (i_op == ras_pkg::OP_SEARCH);

    assign we    = load_acc && (i_first || (r_cnt < CW'(DEPTH)));
    assign waddr = i_first ? '0 : AW'(r_cnt);

    assign lo_ext  = CW'(r_lo);
    assign mid_sum = (CW + 1)'(lo_ext) + (CW + 1)'(r_hi);
    assign mid     = AW'(mid_sum >> 1);
    assign hi_m1   = AW'(r_hi - CW'(1));
    assign len     = r_hi - lo_ext;

    always_comb begin
        case (i_ctrl.addr_sel)
            ras_pkg::ADDR_LO: raddr = r_lo;
            ras_pkg::ADDR_HI: raddr = hi_m1;
            default:          raddr = mid;
        endcase
    end

    ras_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (VALUE_BITS'(i_element)),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign rdata = ram_rdata;

    assign nonempty = (lo_ext < r_hi);
    assign eq_m     = (r_tgt == r_mv);
    assign eq_l     = (r_tgt == r_lv);
    assign eq_r     = (r_tgt == r_rv);
    assign hit      = nonempty && (eq_m || eq_l || eq_r);
    assign done     = !nonempty || hit || (len <= CW'(2));

    always_comb begin
        if (eq_m) begin
            hit_pos = mid;
        end else if (eq_l) begin
            hit_pos = r_lo;
        end else begin
            hit_pos = hi_m1;
        end
    end

    assign hit_pos_w = PW'(hit_pos);

    assign go_hi_mid = (r_tgt <= r_rv && r_tgt <= r_mv && r_tgt >= r_lv)
                    || (r_tgt >= r_lv && r_tgt <= r_mv);
    assign go_lo_mid = (r_tgt >= r_mv && r_tgt <= r_rv) || (r_tgt <= r_rv);

    assign out_block = r_out_valid && i_stall;
    assign out_write = i_ctrl.decide && done && !out_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else begin
            if (load_acc) begin
                if (i_first) begin
                    r_cnt <= CW'(1);
                end else if (r_cnt < CW'(DEPTH)) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (search_acc) begin
                r_lo <= '0;
                r_hi <= r_cnt;
            end else if (i_ctrl.decide && !done) begin
                if (go_hi_mid) begin
                    r_hi <= CW'(mid);
                end else if (go_lo_mid) begin
                    r_lo <= mid;
                end else begin
                    r_hi <= CW'(mid) + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (search_acc) begin
            r_tgt <= VALUE_BITS'(i_target);
        end
        case (i_ctrl.cap_sel)
            ras_pkg::CAP_MID: r_mv <= rdata;
            ras_pkg::CAP_LO:  r_lv <= rdata;
            ras_pkg::CAP_HI:  r_rv <= rdata;
            default: begin
            end
        endcase
        if (out_write) begin
            r_found <= hit;
            r_pos   <= hit ? hit_pos_w[ras_pkg::POS_BITS-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_write) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.empty     = !nonempty;
    assign o_stat.done      = done;
    assign o_stat.out_block = out_block;
    assign o_valid          = r_out_valid;
    assign o_found          = r_found;
    assign o_position       = r_pos;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("element count exceeds depth");

    a_range_in_array: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.decide |-> (r_hi <= r_cnt))
        else $error("search range extends past the loaded elements");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_position == '0))
        else $error("not-found result carries a nonzero position");

    a_write_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_block && i_ctrl.decide) |=> $stable(r_found))
        else $error("pending result overwritten while stalled");

endmodule

/* sv/rotated_array_search.sv */
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_op, i_first, i_element, i_target
// output   out        o_valid / i_stall   o_found, o_position
//
// A load transaction produces no result.
// A search runs range steps until one matches or gives up, about log2 of the
// element count of them; a search on an empty array goes from its mid step
// straight to the decide step. Each range step reads three words through the
// single read port of the element memory, one after another, and decides.
// Reset clears the element count, the search range, the output valid and the sequencer step.
// The result waits in an output register; a stalled result holds the
// sequencer at its decide step only when another search finishes behind it.
module rotated_array_search #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic                          i_first,
    input  logic signed [31:0]            i_element,
    input  logic signed [31:0]            i_target,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [ras_pkg::POS_BITS-1:0]  o_position
);

    ras_pkg::t_ctrl ctrl;
    ras_pkg::t_stat stat;

    ras_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_stall (o_stall)
    );

    ras_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_op       (i_op),
        .i_first    (i_first),
        .i_element  (i_element),
        .i_target   (i_target),
        .i_stall    (i_stall),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_found    (o_found),
        .o_position (o_position)
    );

endmodule

/* tb/rotated_array_search_tb.sv */
module rotated_array_search_tb;

    localparam int DEPTH        = 1024;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_ITEMS = 700;
    localparam int PRINT_LIMIT  = 100;

    typedef struct {
        logic                         found;
        logic [ras_pkg::POS_BITS-1:0] position;
    } t_search_outcome;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_op;
    logic                          i_first;
    logic signed [31:0]            i_element;
    logic signed [31:0]            i_target;
    logic                          o_valid;
    logic                          i_stall;
    logic                          o_found;
    logic [ras_pkg::POS_BITS-1:0]  o_position;

    logic signed [31:0]   array_words [DEPTH];
    int unsigned          array_length;
    t_search_outcome      search_outcomes [$];
    int                   loaded_words [$];
    int                   last_rotation;
    int                   burst_left;
    int                   mismatch_count;
    bit                   hold_request;

    rotated_array_search #(
        .DEPTH(DEPTH),
        .VALUE_BITS(32)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_op(i_op),
        .i_first(i_first),
        .i_element(i_element),
        .i_target(i_target),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_found(o_found),
        .o_position(o_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_search_outcome locate_target(input logic signed [31:0] target);
        t_search_outcome    res;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        logic signed [31:0] lv;
        logic signed [31:0] mv;
        logic signed [31:0] rv;
        res.found = 1'b0;
        res.position = '0;
        lo = 0;
        hi = array_length;
        for (int guard = 0; guard <= DEPTH + 1; guard++) begin
            if (lo >= hi || hi > DEPTH) break;
            mid = (lo + hi) / 2;
            lv = array_words[lo];
            mv = array_words[mid];
            rv = array_words[hi - 1];
            if (target == mv) begin
                res.found = 1'b1;
                res.position = ras_pkg::POS_BITS'(mid);
                break;
            end
            if (target == lv) begin
                res.found = 1'b1;
                res.position = ras_pkg::POS_BITS'(lo);
                break;
            end
            if (target == rv) begin
                res.found = 1'b1;
                res.position = ras_pkg::POS_BITS'(hi - 1);
                break;
            end
            if (hi - lo <= 2) break;
            if (target <= rv && target <= mv && target >= lv) hi = mid;
            else if (target >= lv && target <= mv) hi = mid;
            else if (target >= mv && target <= rv) lo = mid;
            else if (target <= rv) lo = mid;
            else hi = mid + 1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // The sender works in bursts; the transaction is taken at the edge after a
    // falling edge that sees valid high and stall low.
    task automatic send_item(input logic op, input logic first,
                             input logic signed [31:0] element,
                             input logic signed [31:0] target);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_first <= first;
        i_element <= element;
        i_target <= target;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        if (op == ras_pkg::OP_LOAD) begin
            if (first) array_length = 0;
            if (array_length < DEPTH) begin
                array_words[array_length] = element;
                array_length++;
            end
        end else begin
            search_outcomes.push_back(locate_target(target));
        end
    endtask

    task automatic load_rotated(input int n, input bit narrow);
        longint      value;
        int unsigned step_max;
        step_max = narrow ? 3 : 32'hFFFF_FFFF / (n + 1);
        value = narrow ? -longint'(n) : longint'(32'sh8000_0000) + $urandom_range(0, step_max);
        loaded_words.delete();
        for (int k = 0; k < n; k++) begin
            loaded_words.push_back(int'(value));
            value += $urandom_range(0, step_max);
        end
        last_rotation = $urandom_range(0, n - 1);
        for (int k = 0; k < n; k++) begin
            send_item(ras_pkg::OP_LOAD, k == 0, loaded_words[(k + last_rotation) % n],
                      $urandom());
        end
    endtask

    function automatic logic signed [31:0] pick_target();
        int idx;
        idx = $urandom_range(0, loaded_words.size() - 1);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return loaded_words[idx];
            4: return loaded_words[idx] + 1;
            5: return loaded_words[idx] - 1;
            6: return ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_empty_array();
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, 32'sd0);
        send_item(ras_pkg::OP_SEARCH, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    endtask

    task automatic test_small_ranges();
        send_item(ras_pkg::OP_LOAD, 1'b1, 32'sd42, 32'sd0);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, 32'sd42);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, 32'sd41);
        send_item(ras_pkg::OP_LOAD, 1'b1, 32'sd5, 32'sd0);
        send_item(ras_pkg::OP_LOAD, 1'b0, -32'sd3, 32'sd0);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, -32'sd3);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, 32'sd5);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, 32'sd0);
    endtask

    task automatic test_field_extremes();
        send_item(ras_pkg::OP_LOAD, 1'b1, 32'sd100, 32'sh7FFF_FFFF);
        send_item(ras_pkg::OP_LOAD, 1'b0, 32'sh7FFF_FFFF, -32'sd1);
        send_item(ras_pkg::OP_LOAD, 1'b0, 32'sh8000_0000, 32'sh8000_0000);
        send_item(ras_pkg::OP_LOAD, 1'b0, -32'sd5, 32'sd0);
        send_item(ras_pkg::OP_LOAD, 1'b0, 32'sd0, 32'sd0);
        send_item(ras_pkg::OP_LOAD, 1'b0, 32'sd7, 32'sd0);
        send_item(ras_pkg::OP_SEARCH, 1'b1, -32'sd1, 32'sh8000_0000);
        send_item(ras_pkg::OP_SEARCH, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sh8000_0000, 32'sd7);
        send_item(ras_pkg::OP_SEARCH, 1'b1, 32'sd0, 32'sd100);
        send_item(ras_pkg::OP_SEARCH, 1'b0, -32'sd1, 32'sd8);
        send_item(ras_pkg::OP_SEARCH, 1'b1, 32'sd0, -32'sd1);
    endtask

    // Fills every entry, then offers more loads that must be dropped.
    task automatic test_full_array();
        logic signed [31:0] dropped;
        load_rotated(DEPTH, 1'b0);
        dropped = $urandom();
        send_item(ras_pkg::OP_LOAD, 1'b0, dropped, $urandom());
        send_item(ras_pkg::OP_LOAD, 1'b0, $urandom(), $urandom());
        send_item(ras_pkg::OP_LOAD, 1'b0, $urandom(), $urandom());
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0,
                  loaded_words[(DEPTH - 1 + last_rotation) % DEPTH]);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, loaded_words[last_rotation]);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, loaded_words[0]);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, loaded_words[DEPTH - 1]);
        send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, dropped);
        repeat (12) send_item(ras_pkg::OP_SEARCH, $urandom_range(0, 1), $urandom(),
                              pick_target());
    endtask

    task automatic test_result_backpressure();
        load_rotated(16, 1'b0);
        hold_request = 1'b1;
        repeat (12) send_item(ras_pkg::OP_SEARCH, 1'b0, 32'sd0, pick_target());
    endtask

    task automatic test_random_sequences();
        int items;
        int n;
        int searches;
        items = 0;
        while (items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
                load_rotated(n, $urandom_range(0, 2) == 0);
                searches = $urandom_range(1, 8);
                repeat (searches) begin
                    send_item(ras_pkg::OP_SEARCH, $urandom_range(0, 1), $urandom(),
                              pick_target());
                end
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    send_item(ras_pkg::OP_LOAD, $urandom_range(0, 5) == 0, $urandom(),
                              $urandom());
                end
                searches = $urandom_range(1, 3);
                repeat (searches) begin
                    send_item(ras_pkg::OP_SEARCH, $urandom_range(0, 1), $urandom(),
                              $urandom());
                end
            end
            items += n + searches;
        end
    endtask

    initial begin : result_stall_pattern
        int mode;
        int span;
        int hold_left;
        mode = 0;
        span = 0;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(1, 60);
                end
                span--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 9) < 3);
                    2: i_stall <= ($urandom_range(0, 9) < 8);
                    default: i_stall <= span[1];
                endcase
            end
        end
    end

    initial begin : result_check
        t_search_outcome want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (search_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: found=%0b position=%0d",
                                              o_found, o_position));
                end else begin
                    want = search_outcomes.pop_front();
                    if (o_found !== want.found) begin
                        report_mismatch($sformatf("found=%0b, wanted %0b", o_found, want.found));
                    end
                    if (o_position !== want.position) begin
                        report_mismatch($sformatf("position=%0d, wanted %0d",
                                                  o_position, want.position));
                    end
                end
            end
        end
    end

    initial begin : acceptance_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        array_length = 0;
        burst_left = 0;
        mismatch_count = 0;
        hold_request = 1'b0;
        last_rotation = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op <= ras_pkg::OP_LOAD;
        i_first <= 1'b0;
        i_element <= '0;
        i_target <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_array();
        test_small_ranges();
        test_field_extremes();
        test_full_array();
        test_result_backpressure();
        test_random_sequences();

        i_valid <= 1'b0;
        while (search_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
